/* design/pulse_rate_peak_detector_top_defines.svh */
// assertion macros for the pulse rate peak detector
`ifndef PULSE_RATE_PEAK_DETECTOR_TOP_DEFINES_SVH
`define PULSE_RATE_PEAK_DETECTOR_TOP_DEFINES_SVH

// assert that a condition implies a consequence in the same cycle
`define PRPD_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// assert that a condition implies a consequence in the next cycle
`define PRPD_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* design/prpd_pkg.sv */
// shared constants and types for the pulse rate peak detector
package prpd_pkg;

    localparam int Depth    = 60;
    localparam int MaxPeaks = 20;
    localparam int IdxW     = $clog2(Depth);
    localparam int CntW     = $clog2(Depth + 1);
    localparam int PkW      = $clog2(MaxPeaks + 1);
    localparam int SumW     = 16 + CntW;
    localparam logic [31:0] BpmNum = 32'd60000;

    // configuration register indexes
    localparam logic [2:0] REG_THRESH  = 3'd0;
    localparam logic [2:0] REG_SPACING = 3'd1;
    localparam logic [2:0] REG_MINSAMP = 3'd2;
    localparam logic [2:0] REG_EVERY   = 3'd3;
    localparam logic [2:0] REG_LOW     = 3'd4;
    localparam logic [2:0] REG_HIGH    = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_SUM,
        ST_DIV1,
        ST_SCAN,
        ST_DIV2,
        ST_DIV3,
        ST_FIN,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mod_start;
        logic sum_start;
        logic div1_start;
        logic scan_start;
        logic div2_start;
        logic div3_start;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic present;
        logic mod_done;
        logic do_compute;
        logic sum_done;
        logic div_done;
        logic scan_done;
        logic enough_peaks;
        logic avg_zero;
    } status_t;

endpackage

/* design/prpd_datapath.sv */
// datapath: sample rings, mean, peak scan, serial divider and held rate
module prpd_datapath
    import prpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [15:0] ir_sample,
    input  logic [31:0] timestamp_ms,
    input  logic [15:0] presence_level,
    input  logic [5:0]  min_spacing,
    input  logic [5:0]  min_samples,
    input  logic [5:0]  compute_every,
    input  logic [7:0]  rate_low,
    input  logic [7:0]  rate_high,
    output logic [7:0]  pulse_bpm,
    output logic        finger_present
);

    logic [15:0] sample_mem [Depth];
    logic [31:0] time_mem [Depth];

    logic [IdxW-1:0] wp_reg;
    logic [CntW-1:0] fill_reg;
    logic [7:0]      held_reg;
    logic            present_reg;

    // scan side
    logic [IdxW-1:0] rd_idx_reg;
    logic [CntW-1:0] cnt_reg;
    logic            rd_valid_reg;
    logic [15:0]     rv_reg;
    logic [31:0]     rt_reg;
    logic [SumW-1:0] sum_reg;
    logic [15:0]     v0_reg, v1_reg;
    logic [31:0]     t1_reg;
    logic [CntW-1:0] last_reg;
    logic            have_last_reg;
    logic [PkW-1:0]  peaks_reg;
    logic [31:0]     first_t_reg, last_t_reg;
    logic [CntW-1:0] got_reg;
    logic            done_reg;
    logic [5:0]      mod_reg;

    // serial divider
    logic [31:0] dnum_reg, ddiv_reg, dq_reg, drem_reg;
    logic [5:0]  dstep_reg;
    logic        dbusy_reg;

    logic [IdxW:0] start_calc;
    logic [IdxW-1:0] next_idx;
    logic [32:0] rem_shift;
    logic [CntW-1:0] fill_inc;

    assign finger_present = present_reg;
    assign pulse_bpm      = held_reg;

    assign start_calc = {1'b0, wp_reg} + (IdxW+1)'(Depth) - (IdxW+1)'(fill_reg);
    assign next_idx   = (rd_idx_reg == IdxW'(Depth - 1)) ? '0 : rd_idx_reg + 1'b1;
    assign rem_shift  = {drem_reg, dnum_reg[31]};
    // fill count after a word with finger, saturating at the ring depth
    assign fill_inc   = (fill_reg != CntW'(Depth)) ? fill_reg + 1'b1 : fill_reg;

    assign status.present      = ir_sample > presence_level;
    assign status.mod_done     = (mod_reg < compute_every) || (compute_every == 6'd0);
    assign status.do_compute   = (compute_every != 6'd0) && (mod_reg == 6'd0)
                                 && (fill_reg >= CntW'(min_samples));
    assign status.sum_done     = done_reg;
    assign status.div_done     = !dbusy_reg;
    assign status.scan_done    = done_reg;
    assign status.enough_peaks = peaks_reg >= PkW'(2);
    assign status.avg_zero     = dq_reg == 32'd0;

    // ring write on accept of a word with finger, and registered ring read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.present)
        begin
            sample_mem[wp_reg] <= ir_sample;
            time_mem[wp_reg]   <= timestamp_ms;
        end
        rv_reg <= sample_mem[rd_idx_reg];
        rt_reg <= time_mem[rd_idx_reg];
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; fill_reg <= '0; held_reg <= '0; present_reg <= 1'b0;
            rd_valid_reg <= 1'b0; done_reg <= 1'b0; dbusy_reg <= 1'b0;
            mod_reg <= '0; cnt_reg <= '0; rd_idx_reg <= '0; dstep_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                present_reg <= status.present;
                if (status.present)
                begin
                    wp_reg <= (wp_reg == IdxW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
                    fill_reg <= fill_inc;
                end
                else
                begin
                    wp_reg <= '0; fill_reg <= '0; held_reg <= '0;
                end
            end
            // remainder of the updated fill by compute_every, by repeated subtraction
            if (cmd.mod_start)
                mod_reg <= 6'(fill_inc);
            else if (!status.mod_done)
                mod_reg <= mod_reg - compute_every;
            // ring walk for sum and scan
            if (cmd.sum_start || cmd.scan_start)
            begin
                rd_idx_reg   <= start_calc >= (IdxW+1)'(Depth)
                                ? IdxW'(start_calc - (IdxW+1)'(Depth)) : IdxW'(start_calc);
                cnt_reg      <= fill_reg;
                rd_valid_reg <= 1'b0;
                done_reg     <= 1'b0;
            end
            else if (cnt_reg != '0)
            begin
                rd_idx_reg   <= next_idx;
                cnt_reg      <= cnt_reg - 1'b1;
                rd_valid_reg <= 1'b1;
            end
            else if (rd_valid_reg)
            begin
                rd_valid_reg <= 1'b0;
                done_reg     <= 1'b1;
            end
            // divider control
            if (cmd.div1_start || cmd.div2_start || cmd.div3_start)
            begin
                dbusy_reg <= 1'b1; dstep_reg <= '0;
            end
            else if (dbusy_reg)
            begin
                dstep_reg <= dstep_reg + 1'b1;
                if (dstep_reg == 6'd31)
                    dbusy_reg <= 1'b0;
            end
            // held rate update
            if (cmd.finish && status.enough_peaks && !status.avg_zero &&
                dq_reg != 32'd0 && dq_reg >= {24'd0, rate_low} &&
                dq_reg <= {24'd0, rate_high})
                held_reg <= dq_reg[7:0];
        end
    end

    // sum, scan and divider payload
    always_ff @(posedge clk)
    begin
        if (cmd.sum_start)
            sum_reg <= '0;
        else if (rd_valid_reg && !cmd.scan_start)
            sum_reg <= sum_reg + SumW'(rv_reg);

        if (cmd.scan_start)
        begin
            got_reg <= '0; have_last_reg <= 1'b0;
            peaks_reg <= '0; last_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            got_reg <= got_reg + 1'b1;
            v0_reg <= v1_reg; v1_reg <= rv_reg; t1_reg <= rt_reg;
            // candidate at position got-1 using v0, v1, rv
            if (got_reg >= CntW'(2))
            begin
                if ({16'd0, v1_reg} > dq_reg && v1_reg > v0_reg && v1_reg > rv_reg &&
                    (!have_last_reg || (got_reg - 1'b1 - last_reg) >= CntW'(min_spacing)))
                begin
                    last_reg <= got_reg - 1'b1;
                    have_last_reg <= 1'b1;
                    if (peaks_reg < PkW'(MaxPeaks))
                    begin
                        peaks_reg <= peaks_reg + 1'b1;
                        if (peaks_reg == '0)
                            first_t_reg <= t1_reg;
                        last_t_reg <= t1_reg;
                    end
                end
            end
        end

        // restoring divider, one quotient bit per cycle
        if (cmd.div1_start)
        begin
            dnum_reg <= 32'(sum_reg); ddiv_reg <= 32'(fill_reg);
            drem_reg <= '0; dq_reg <= '0;
        end
        else if (cmd.div2_start)
        begin
            dnum_reg <= last_t_reg - first_t_reg;
            ddiv_reg <= 32'(peaks_reg) - 32'd1;
            drem_reg <= '0; dq_reg <= '0;
        end
        else if (cmd.div3_start)
        begin
            dnum_reg <= BpmNum; ddiv_reg <= dq_reg;
            drem_reg <= '0; dq_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            dnum_reg <= {dnum_reg[30:0], 1'b0};
            if (rem_shift >= {1'b0, ddiv_reg})
            begin
                drem_reg <= 32'(rem_shift - {1'b0, ddiv_reg});
                dq_reg   <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                drem_reg <= rem_shift[31:0];
                dq_reg   <= {dq_reg[30:0], 1'b0};
            end
        end
    end

endmodule

/* design/prpd_controller.sv */
// controller: sequences accept, compute steps and result delivery
module prpd_controller
    import prpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = status.present ? ST_MOD : ST_OUT;
            ST_MOD:  if (status.mod_done)
                         state_next = status.do_compute ? ST_SUM : ST_OUT;
            ST_SUM:  if (status.sum_done) state_next = ST_DIV1;
            ST_DIV1: if (status.div_done) state_next = ST_SCAN;
            ST_SCAN: if (status.scan_done)
                         state_next = status.enough_peaks ? ST_DIV2 : ST_OUT;
            ST_DIV2: if (status.div_done)
                         state_next = status.avg_zero ? ST_OUT : ST_DIV3;
            ST_DIV3: if (status.div_done) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        in_stall  = state_reg != ST_IDLE;
        out_valid = state_reg == ST_OUT;
        case (state_reg)
            ST_IDLE: begin cmd.accept = in_valid; cmd.mod_start = in_valid; end
            ST_MOD:  cmd.sum_start  = status.mod_done && status.do_compute;
            ST_SUM:  cmd.div1_start = status.sum_done;
            ST_DIV1: cmd.scan_start = status.div_done;
            ST_SCAN: cmd.div2_start = status.scan_done && status.enough_peaks;
            ST_DIV2: cmd.div3_start = status.div_done && !status.avg_zero;
            ST_FIN:  cmd.finish = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* design/pulse_rate_peak_detector_top.sv */
// top level of the pulse rate peak detector
//  channel | signals                                     | direction
//  in      | in_valid in_stall ir_sample timestamp_ms      | into block
//  out     | out_valid out_stall pulse_bpm finger_present  | out of block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data        | into block
// one word at a time; a word without finger goes from accept to the output stage
// a word with finger and no compute also takes the mod step (repeated subtraction)
// a compute adds two ring walks (sum, peak scan) and serial divisions for the mean,
// the peak interval if two or more peaks, and the rate if that interval is nonzero
// the result waits in the output stage while out_stall is high; no new word meanwhile
// reset clears control state and restores register defaults
module pulse_rate_peak_detector_top
    import prpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] ir_sample,
    input  logic [31:0] timestamp_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pulse_bpm,
    output logic        finger_present,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] thresh_reg;
    logic [5:0]  spacing_reg, minsamp_reg, every_reg;
    logic [7:0]  low_reg, high_reg;
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= 16'd5000; spacing_reg <= 6'd5; minsamp_reg <= 6'd10;
            every_reg <= 6'd5; low_reg <= 8'd30; high_reg <= 8'd220;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESH:  thresh_reg  <= cfg_data;
                REG_SPACING: spacing_reg <= cfg_data[5:0];
                REG_MINSAMP: minsamp_reg <= cfg_data[5:0];
                REG_EVERY:   every_reg   <= cfg_data[5:0];
                REG_LOW:     low_reg     <= cfg_data[7:0];
                REG_HIGH:    high_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    prpd_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
    );

    prpd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .ir_sample(ir_sample), .timestamp_ms(timestamp_ms),
        .presence_level(thresh_reg), .min_spacing(spacing_reg),
        .min_samples(minsamp_reg), .compute_every(every_reg),
        .rate_low(low_reg), .rate_high(high_reg),
        .pulse_bpm(pulse_bpm), .finger_present(finger_present)
    );

endmodule

/* design/prpd_checker.sv */
// port-level checker for the pulse rate peak detector, bound to the top level
`include "pulse_rate_peak_detector_top_defines.svh"
module prpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] pulse_bpm,
    input logic       finger_present
);
    // result without finger reports no rate
    `PRPD_ASSERT_IMP(a_nofinger, clk, rst_n, out_valid && !finger_present, pulse_bpm == 8'd0, "rate without finger")
    // no input taken while a result waits
    `PRPD_ASSERT_IMP(a_busy, clk, rst_n, out_valid, in_stall, "input taken with result pending")
    // stalled result holds
    `PRPD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pulse_bpm), "stalled result changed")
    // accepted word holds off the input on the next cycle
    `PRPD_ASSERT_NEXT(a_lat, clk, rst_n, in_valid && !in_stall, in_stall, "input taken back to back")
endmodule

bind pulse_rate_peak_detector_top prpd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .pulse_bpm(pulse_bpm),
    .finger_present(finger_present)
);

/* dv/tb_top.sv */
// self-checking testbench for the pulse rate peak detector
module tb_top;
    import prpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] ir;
        logic [31:0] ts;
    } sample_word_t;

    typedef struct {
        logic [7:0] rate;
        logic       present;
    } rate_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] ir_sample = '0;
    logic [31:0] timestamp_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  pulse_bpm;
    logic        finger_present;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    pulse_rate_peak_detector_top dut (.*);

    always #1 clk = ~clk;

    // predictor state
    logic [15:0] ring_val [Depth];
    logic [31:0] ring_time [Depth];
    int unsigned wr_ptr, fill, held;
    int unsigned thresh, spacing, min_fill, every, low_bpm, high_bpm;

    sample_word_t pending_words[$];
    rate_word_t   expected_rates[$];
    int           errors;
    int           results_seen;
    int           send_idle_pct, stall_pct;
    bit           long_stall;
    int           word_count;

    function automatic int unsigned pulse_rate();
        logic [15:0] v [Depth];
        logic [31:0] t [Depth];
        logic [31:0] pk [MaxPeaks];
        int unsigned npk, last, start, mean, avg, bpm;
        logic [31:0] total;
        longint unsigned sum;
        bit have_last;
        npk = 0; last = 0; have_last = 0; sum = 0; total = 0;
        if (fill == 0) return 0;
        start = (wr_ptr + Depth - fill) % Depth;
        for (int i = 0; i < fill; i++)
        begin
            v[i] = ring_val[(start + i) % Depth];
            t[i] = ring_time[(start + i) % Depth];
            sum += v[i];
        end
        mean = 32'(sum / fill);
        for (int i = 1; i + 1 < fill; i++)
        begin
            if (v[i] > mean && v[i] > v[i-1] && v[i] > v[i+1] &&
                (!have_last || i - last >= spacing))
            begin
                if (npk < MaxPeaks)
                begin
                    pk[npk] = t[i];
                    npk++;
                end
                last = i;
                have_last = 1;
            end
        end
        if (npk < 2) return 0;
        for (int i = 1; i < npk; i++) total += pk[i] - pk[i-1];
        avg = total / (npk - 1);
        if (avg == 0) return 0;
        bpm = 60000 / avg;
        if (bpm < low_bpm || bpm > high_bpm) return 0;
        return bpm;
    endfunction

    function automatic rate_word_t predict_rate(sample_word_t w);
        rate_word_t r;
        int unsigned bpm;
        r.present = w.ir > thresh;
        if (r.present)
        begin
            ring_val[wr_ptr] = w.ir;
            ring_time[wr_ptr] = w.ts;
            wr_ptr = (wr_ptr + 1) % Depth;
            if (fill < Depth) fill++;
            if (every != 0 && fill % every == 0 && fill >= min_fill)
            begin
                bpm = pulse_rate();
                if (bpm > 0) held = bpm;
            end
        end
        else
        begin
            wr_ptr = 0;
            fill = 0;
            held = 0;
        end
        r.rate = held[7:0];
        return r;
    endfunction

    // driver: offers queued words, predicting each one as it is accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_rates.push_back(predict_rate(pending_words.pop_front()));
            if ((!in_valid || !in_stall))
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    ir_sample <= pending_words[0].ir;
                    timestamp_ms <= pending_words[0].ts;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_rates.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    rate_word_t e;
                    e = expected_rates.pop_front();
                    if (pulse_bpm !== e.rate)
                    begin
                        $error("pulse_bpm exp %0d got %0d", e.rate, pulse_bpm);
                        errors++;
                    end
                    if (finger_present !== e.present)
                    begin
                        $error("finger_present exp %0d got %0d", e.present, finger_present);
                        errors++;
                    end
                end
            end
            out_stall <= long_stall || ($urandom_range(99) < stall_pct);
        end
    end

    // long receiver hold-off so the block backs up
    initial
    begin
        long_stall = 0;
        wait (word_count > 300);
        long_stall = 1;
        repeat (400) @(posedge clk);
        long_stall = 0;
    end

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_THRESH:  thresh = val[15:0];
            REG_SPACING: spacing = val[5:0];
            REG_MINSAMP: min_fill = val[5:0];
            REG_EVERY:   every = val[5:0];
            REG_LOW:     low_bpm = val[7:0];
            REG_HIGH:    high_bpm = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && expected_rates.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    task automatic add_word(logic [15:0] ir, logic [31:0] ts);
        sample_word_t w;
        w.ir = ir;
        w.ts = ts;
        pending_words.push_back(w);
        word_count++;
    endtask

    // periodic pulse train with random period, amplitude and noise
    task automatic add_pulse_train(int n);
        int period, base, amp;
        logic [31:0] ts;
        period = $urandom_range(4, 20);
        base = $urandom_range(thresh + 1 > 60000 ? 60000 : thresh + 1, 62000);
        amp = $urandom_range(100, 3000);
        ts = $urandom;
        for (int i = 0; i < n; i++)
        begin
            int v;
            v = base + ((i % period) == period / 2 ? amp : (i % period) * 7)
                + $urandom_range(0, 20);
            if (v > 65535) v = 65535;
            if (v <= thresh) v = thresh + 1;
            if ($urandom_range(99) < 3) v = $urandom;
            add_word(16'(v), ts);
            ts += $urandom_range(20, 140);
        end
    endtask

    task automatic set_idle(int s, int r);
        send_idle_pct = s;
        stall_pct = r;
    endtask

    initial
    begin
        errors = 0; results_seen = 0; word_count = 0;
        wr_ptr = 0; fill = 0; held = 0;
        thresh = 5000; spacing = 5; min_fill = 10; every = 5;
        low_bpm = 30; high_bpm = 220;
        set_idle(0, 0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, no-finger clears, wrapping timestamps
        write_reg(REG_EVERY, 1);
        write_reg(REG_MINSAMP, 3);
        write_reg(REG_SPACING, 1);
        add_word(16'd0, 32'hFFFF_FFFF);
        add_word(16'd5000, 32'd0);
        add_word(16'hFFFF, 32'hFFFF_FFF0);
        add_word(16'd6000, 32'hFFFF_FFF8);
        add_word(16'hFFFF, 32'h0000_01F0);
        add_word(16'd6000, 32'h0000_0200);
        add_word(16'hFFFF, 32'h0000_03E8);
        add_word(16'd6000, 32'h0000_0400);
        add_word(16'hFFFF, 32'h0000_03E8);
        add_word(16'd6000, 32'h0000_0500);
        add_word(16'd5001, 32'h5555_5555);
        add_word(16'hAAAA, 32'hAAAA_AAAA);
        add_word(16'h5555, 32'h5555_5555);
        add_word(16'd100, 32'd7);
        drain();

        // several register settings, including extremes
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: set_idle(0, 0);
                1: set_idle(68, 0);
                2: set_idle(0, 68);
                default: set_idle(15, 15);
            endcase
            write_reg(REG_THRESH, phase == 7 ? 16'hFFFF : (phase == 6 ? 16'd0
                                                             : $urandom_range(0, 20000)));
            write_reg(REG_SPACING, phase == 0 ? 6'd63 : (phase == 1 ? 6'd0
                                                           : $urandom_range(1, 10)));
            write_reg(REG_MINSAMP, phase == 2 ? 6'd60 : $urandom_range(3, 20));
            write_reg(REG_EVERY, phase == 3 ? 6'd0 : (phase == 4 ? 6'd60
                                                        : $urandom_range(1, 6)));
            write_reg(REG_LOW, phase == 5 ? 8'd250 : (phase == 1 ? 8'hFF : $urandom_range(0, 40)));
            write_reg(REG_HIGH, phase == 5 ? 8'd10 : (phase == 2 ? 8'd0 : 8'hFF));
            for (int k = 0; k < 2; k++)
            begin
                add_pulse_train($urandom_range(20, 48));
                if ($urandom_range(1)) add_word(16'($urandom_range(0, thresh)), $urandom);
            end
            drain();
        end

        $display("covered %0d words, %0d results over 8 register settings and idle mixes",
                 word_count, results_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
